FILE: src/mme_pkg.sv
package mme_pkg;

  localparam int MAX_DIM  = 16;
  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] CMD_WRITE_A  = 2'd0;
  localparam logic [1:0] CMD_WRITE_B  = 2'd1;
  localparam logic [1:0] CMD_MULTIPLY = 2'd2;
  localparam logic [1:0] CMD_READ_C   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHAPE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  typedef struct packed {
    logic [1:0]               command;
    logic [3:0]               row;
    logic [3:0]               col;
    logic signed [DATA_W-1:0] element_value;
  } mme_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
  } mme_out_t;

  // operand moving down the cell chain
  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     last;
    logic [IDX_W-1:0]         k;
    logic [IDX_W-1:0]         row;
    logic signed [DATA_W-1:0] a;
  } mme_lane_t;

  // broadcast write of a B element
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] data;
  } mme_bwr_t;

  // finished dot product from one cell
  typedef struct packed {
    logic                     done;
    logic [IDX_W-1:0]         row;
    logic signed [DATA_W-1:0] value;
  } mme_res_t;

endpackage

FILE: src/mme_cell.sv
module mme_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [mme_pkg::IDX_W-1:0] col_id,
  input  mme_pkg::mme_bwr_t  bwr_i,
  input  mme_pkg::mme_lane_t lane_i,
  output mme_pkg::mme_lane_t lane_o,
  output mme_pkg::mme_res_t  res_o
);
  import mme_pkg::*;

  logic signed [DATA_W-1:0] bcol_r [MAX_DIM];
  mme_lane_t                lane_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     done_r;
  logic [IDX_W-1:0]         drow_r;
  logic signed [DATA_W-1:0] sat;

  // local column of B
  always_ff @(posedge clk) begin
    if (bwr_i.en && bwr_i.col == col_id) begin
      bcol_r[bwr_i.row] <= bwr_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      lane_r.valid <= lane_i.valid;
      done_r       <= lane_r.valid && lane_r.last;
    end
    lane_r.first <= lane_i.first;
    lane_r.last  <= lane_i.last;
    lane_r.k     <= lane_i.k;
    lane_r.row   <= lane_i.row;
    lane_r.a     <= lane_i.a;
    prod_r       <= PROD_W'(lane_i.a) * PROD_W'(bcol_r[lane_i.k]);
    if (lane_r.valid) begin
      acc_r  <= acc_nxt;
      drow_r <= lane_r.row;
    end
  end

  always_comb begin
    if (lane_r.first) acc_nxt = ACC_W'(prod_r);
    else              acc_nxt = acc_r + ACC_W'(prod_r);
  end

  // floor to Q16.16, saturate
  always_comb begin
    if (&acc_r[ACC_W-1:DATA_W+FRAC_W-1] || ~|acc_r[ACC_W-1:DATA_W+FRAC_W-1]) begin
      sat = acc_r[DATA_W+FRAC_W-1:FRAC_W];
    end else if (acc_r[ACC_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign lane_o      = lane_r;
  assign res_o.done  = done_r;
  assign res_o.row   = drow_r;
  assign res_o.value = sat;

endmodule

FILE: src/matrix_multiply_engine.sv
// Channel | Direction | Payload    | Handshake
// in      | input     | mme_in_t   | in_valid / in_ready
// out     | output    | mme_out_t  | out_valid / out_ready
// cfg     | input     | 5-bit data | cfg_we, no wait
//
// Write A, write B, shape mismatch and out-of-range commands: the result is
// registered in the pending register at the transfer edge, then moves to the
// output register. Read C first passes the S_RD state (registered product
// store read). Multiply: rows of A feed the cell chain from the A store one
// word a cycle while the step index is below K, then the 16-cell chain drains
// in S_DRN and the result is issued as for a write. Reset is synchronous; the
// product store reads as zero after reset via per-entry valid bits. A result
// waits in a pending register while the output register stalls; input is
// taken again once the pending register is free.
module matrix_multiply_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mme_pkg::mme_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mme_pkg::mme_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [mme_pkg::CFG_W-1:0]          cfg_wdata
);
  import mme_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DRN  = 2'd3;
  localparam int DRAIN   = MAX_DIM + 3;
  localparam int DCNT_W  = $clog2(DRAIN);

  logic [CFG_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [DIM_W-1:0] ra, ca, rb, cb, per;
  logic [1:0]       state_r;

  // pending result and output register
  logic     res_valid_r, out_valid_r;
  mme_out_t res_r, out_r;

  // stores
  logic signed [DATA_W-1:0] amem [DEPTH];
  logic signed [DATA_W-1:0] cmem [DEPTH];
  logic [DEPTH-1:0]         cvalid_r;
  logic signed [DATA_W-1:0] a_q, c_q;
  logic                     cv_q;

  // sequencer
  logic [IDX_W-1:0]  fi_r;
  logic [DIM_W-1:0]  fp_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              feed;
  mme_lane_t         al_r, head;
  mme_bwr_t          bwr;

  mme_lane_t lane_o [MAX_DIM];
  mme_res_t  res_c  [MAX_DIM];

  logic              cw_en;
  logic [ADDR_W-1:0] cw_addr;
  logic signed [DATA_W-1:0] cw_data;

  logic acc_in, in_rng, cmd_ok;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (CFG_W'(v) > CFG_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return DIM_W'(v);
  endfunction

  assign ra  = eff_dim(rows_a_r);
  assign ca  = eff_dim(cols_a_r);
  assign rb  = eff_dim(rows_b_r);
  assign cb  = eff_dim(cols_b_r);
  assign per = (ca > cb) ? ca : cb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= CFG_W'(MAX_DIM);
      cols_a_r <= CFG_W'(MAX_DIM);
      rows_b_r <= CFG_W'(MAX_DIM);
      cols_b_r <= CFG_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROWS_A: rows_a_r <= cfg_wdata;
        REG_COLS_A: cols_a_r <= cfg_wdata;
        REG_ROWS_B: rows_b_r <= cfg_wdata;
        REG_COLS_B: cols_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE) && !res_valid_r;
  assign acc_in   = in_valid && in_ready;

  // index check per command
  always_comb begin
    case (in_data.command)
      CMD_WRITE_A: in_rng = (DIM_W'(in_data.row) < ra) && (DIM_W'(in_data.col) < ca);
      CMD_WRITE_B: in_rng = (DIM_W'(in_data.row) < rb) && (DIM_W'(in_data.col) < cb);
      CMD_READ_C:  in_rng = (DIM_W'(in_data.row) < ra) && (DIM_W'(in_data.col) < cb);
      default:     in_rng = 1'b1;
    endcase
  end
  assign cmd_ok = acc_in && in_rng;

  // A store
  always_ff @(posedge clk) begin
    if (cmd_ok && in_data.command == CMD_WRITE_A) begin
      amem[{in_data.row, in_data.col}] <= in_data.element_value;
    end
    a_q <= amem[{fi_r, fp_r[IDX_W-1:0]}];
  end

  assign bwr.en   = cmd_ok && in_data.command == CMD_WRITE_B;
  assign bwr.row  = in_data.row;
  assign bwr.col  = in_data.col;
  assign bwr.data = in_data.element_value;

  // feed A words into the chain, one row per period
  assign feed = (state_r == S_MUL) && (fp_r < ca);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      al_r.valid <= 1'b0;
    end else begin
      al_r.valid <= feed;
    end
    al_r.first <= (fp_r == '0);
    al_r.last  <= (fp_r == ca - DIM_W'(1));
    al_r.k     <= fp_r[IDX_W-1:0];
    al_r.row   <= fi_r;
    al_r.a     <= '0;
  end

  always_comb begin
    head   = al_r;
    head.a = a_q;
  end

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mme_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .col_id (IDX_W'(j)),
      .bwr_i  (bwr),
      .lane_i ((j == 0) ? head : lane_o[(j == 0) ? 0 : j - 1]),
      .lane_o (lane_o[j]),
      .res_o  (res_c[j])
    );
  end

  // cells of one row finish on distinct cycles; pick the one that is done
  always_comb begin
    cw_en   = 1'b0;
    cw_addr = '0;
    cw_data = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      if (res_c[j].done && DIM_W'(j) < cb) begin
        cw_en   = 1'b1;
        cw_addr = {res_c[j].row, IDX_W'(j)};
        cw_data = res_c[j].value;
      end
    end
  end

  // C store
  always_ff @(posedge clk) begin
    if (cw_en) cmem[cw_addr] <= cw_data;
    c_q <= cmem[{in_data.row, in_data.col}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= '0;
    end else if (acc_in && in_data.command == CMD_MULTIPLY && ca == rb) begin
      cvalid_r <= '0;
    end else if (cw_en) begin
      cvalid_r[cw_addr] <= 1'b1;
    end
    cv_q <= cvalid_r[{in_data.row, in_data.col}];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      fi_r        <= '0;
      fp_r        <= '0;
      dcnt_r      <= '0;
    end else begin
      if (res_valid_r && (!out_valid_r || out_ready)) res_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            res_r.read_value <= '0;
            if (!in_rng) begin
              res_r.status <= ST_RANGE;
              res_valid_r  <= 1'b1;
            end else if (in_data.command == CMD_READ_C) begin
              res_r.status <= ST_OK;
              state_r      <= S_RD;
            end else if (in_data.command == CMD_MULTIPLY) begin
              if (ca != rb) begin
                res_r.status <= ST_SHAPE;
                res_valid_r  <= 1'b1;
              end else begin
                res_r.status <= ST_OK;
                state_r      <= S_MUL;
                fi_r         <= '0;
                fp_r         <= '0;
              end
            end else begin
              res_r.status <= ST_OK;
              res_valid_r  <= 1'b1;
            end
          end
        end
        S_RD: begin
          res_r.read_value <= cv_q ? c_q : '0;
          res_valid_r      <= 1'b1;
          state_r          <= S_IDLE;
        end
        S_MUL: begin
          if (fp_r == per - DIM_W'(1)) begin
            fp_r <= '0;
            if (DIM_W'(fi_r) == ra - DIM_W'(1)) begin
              state_r <= S_DRN;
              dcnt_r  <= '0;
            end else begin
              fi_r <= fi_r + IDX_W'(1);
            end
          end else begin
            fp_r <= fp_r + DIM_W'(1);
          end
        end
        S_DRN: begin
          if (dcnt_r == DCNT_W'(DRAIN - 1)) begin
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            dcnt_r <= dcnt_r + DCNT_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid_r && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid_r && (!out_valid_r || out_ready)) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_DRN || state_r == S_RD) |-> !in_ready)
    else $error("input taken while busy");

  a_cwrite_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cw_en |-> (state_r == S_MUL || state_r == S_DRN))
    else $error("product write outside multiply");

  a_pending_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> !in_ready)
    else $error("input taken with pending result");

  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRN && dcnt_r == DCNT_W'(DRAIN - 1)) |=> !cw_en)
    else $error("chain still writing after drain");
`endif

endmodule
